@@ sv/rect_circle_geometry_batcher_core_assert.svh @@
`ifndef RECT_CIRCLE_GEOMETRY_BATCHER_CORE_ASSERT_SVH
`define RECT_CIRCLE_GEOMETRY_BATCHER_CORE_ASSERT_SVH

// same-cycle implication, checked on i_clk outside reset
`define RCGB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcgb check failed");

// next-cycle implication, checked on i_clk outside reset
`define RCGB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcgb check failed");

`endif

@@ sv/rcgb_pkg.sv @@
package rcgb_pkg;

    localparam logic [1:0] REQ_RECT   = 2'd0;
    localparam logic [1:0] REQ_CIRCLE = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_EXTEND   = 2'd2;
    localparam logic [1:0] KIND_OPEN     = 2'd3;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // quarter-wave sine in Q1.16, elaboration use only
    function automatic logic [16:0] quarter_sine(input logic [63:0] r, input int qbits);
        logic [63:0] x, x2, t3, t5, t7, t9, t11, s, q16;
        x   = (r * HALF_PI_Q30 + (64'd1 << (qbits - 1))) >> qbits;
        x2  = (x * x) >> 30;
        t3  = ((x * x2) >> 30) / 6;
        t5  = ((t3 * x2) >> 30) / 20;
        t7  = ((t5 * x2) >> 30) / 42;
        t9  = ((t7 * x2) >> 30) / 72;
        t11 = ((t9 * x2) >> 30) / 110;
        s   = x + t5 + t9 - t3 - t7 - t11;
        q16 = (s + 64'd8192) >> 14;
        if (q16 > 64'd65536) begin
            q16 = 64'd65536;
        end
        return q16[16:0];
    endfunction

    // round r*t / 65536 to nearest, halves away from zero
    function automatic logic signed [17:0] round_scale(input logic signed [33:0] prod);
        logic [33:0] mag;
        logic [33:0] m;
        mag = prod[33] ? 34'(-prod) : 34'(prod);
        m   = (mag + 34'd32768) >> 16;
        return prod[33] ? -$signed(m[17:0]) : $signed(m[17:0]);
    endfunction

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [17:0] b);
        logic signed [18:0] sum;
        sum = 19'(a) + 19'(b);
        if (sum > 19'sd32767) begin
            return 16'sh7fff;
        end else if (sum < -19'sd32768) begin
            return 16'sh8000;
        end
        return sum[15:0];
    endfunction

endpackage

@@ sv/rcgb_trig.sv @@
module rcgb_trig #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic [TRIG_TABLE_BITS-1:0] i_phase,
    output logic signed [17:0]         o_sine
);
    import rcgb_pkg::*;

    localparam int QBITS = TRIG_TABLE_BITS - 2;
    localparam int QTR   = 1 << QBITS;

    typedef logic [16:0] t_sin_tab [QTR+1];

    function automatic t_sin_tab build_tab();
        t_sin_tab tab;
        for (int k = 0; k <= QTR; k++) begin
            tab[k] = quarter_sine(64'(k), QBITS);
        end
        return tab;
    endfunction

    localparam t_sin_tab SinTab = build_tab();

    logic [1:0]       quad;
    logic [QBITS-1:0] rest;
    logic [QBITS:0]   idx;
    logic [16:0]      mag;

    assign quad = i_phase[TRIG_TABLE_BITS-1 -: 2];
    assign rest = i_phase[QBITS-1:0];

    // odd quadrants run the quarter wave backwards
    assign idx = quad[0] ? ((QBITS+1)'(QTR) - {1'b0, rest}) : {1'b0, rest};
    assign mag = SinTab[idx];
    assign o_sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

@@ sv/rect_circle_geometry_batcher_core.sv @@
// Draw-list batcher: one request at a time. A rectangle gives 7 result beats, one a cycle
// when the output is free. A circle of S segments gives 2*S+2 beats and first runs a
// bit-serial divider that finds the phase step; each rim vertex then passes through the
// MULX, MULY and RIM states, since one multiplier and one sine table serve both the
// cosine and the sine products. The input is ready only when idle.
`include "rect_circle_geometry_batcher_core_assert.svh"

module rect_circle_geometry_batcher_core #(
    parameter int MAX_SEGMENTS    = 31,
    parameter int INDEX_BITS      = 20,
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [14:0]        i_extent_w,
    input  logic [14:0]        i_extent_h,
    input  logic [4:0]         i_segments,
    input  logic [31:0]        i_color,
    input  logic [15:0]        i_texture_id,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_vert_x,
    output logic signed [15:0] o_vert_y,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic [31:0]        o_vert_color,
    output logic [19:0]        o_index_a,
    output logic [19:0]        o_index_b,
    output logic [19:0]        o_index_c,
    output logic [19:0]        o_batch_offset,
    output logic [19:0]        o_batch_count,
    output logic               o_last
);
    import rcgb_pkg::*;

    localparam int TB  = TRIG_TABLE_BITS;
    localparam int DW  = $clog2(TB + 1);
    localparam int IB  = INDEX_BITS;
    localparam logic [TB-1:0] QUARTER = TB'(1) << (TB - 2);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_VERT  = 8'b0000_0100,
        ST_MULX  = 8'b0000_1000,
        ST_MULY  = 8'b0001_0000,
        ST_RIM   = 8'b0010_0000,
        ST_TRI   = 8'b0100_0000,
        ST_BATCH = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [31:0]        color;
        logic [19:0]        a;
        logic [19:0]        b;
        logic [19:0]        c;
        logic [19:0]        off;
        logic [19:0]        cnt;
        logic               last;
    } t_beat;

    t_state r_state, n_state;
    logic               r_circ;
    logic signed [15:0] r_px, r_py;
    logic [14:0]        r_w, r_h;
    logic [4:0]         r_segs;
    logic [31:0]        r_color;
    logic [15:0]        r_tex;
    logic [IB-1:0]      r_base;
    logic [4:0]         r_cnt, n_cnt;
    logic [DW-1:0]      r_dcnt;
    logic [4:0]         r_drem;
    logic [TB-1:0]      r_q;
    logic [TB-1:0]      r_p;
    logic [4:0]         r_prem;
    logic signed [33:0] r_prodx, r_prody;
    logic signed [17:0] r_c, r_s;

    logic [IB-1:0]      r_vtotal;
    logic               r_have;
    logic [15:0]        r_btex;
    logic [IB-1:0]      r_bstart, r_bind;

    logic               r_ovalid;
    t_beat              r_out, n_out;

    logic               in_acc, out_step, load;
    logic [4:0]         segs_cl;
    logic [TB-1:0]      trig_phase;
    logic signed [17:0] trig_val;
    logic signed [33:0] prod;
    logic [5:0]         div_try;
    logic [5:0]         prem_sum;
    logic               match;
    logic [IB-1:0]      bcount, nb_start, nb_ind;
    logic [18:0]        u_sum, v_sum;
    logic               tri_done;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_step   = (r_state == ST_VERT) || (r_state == ST_RIM) ||
                        (r_state == ST_TRI) || (r_state == ST_BATCH);
    assign load       = out_step && (!r_ovalid || i_out_ready);

    always_comb begin
        if (i_segments < 5'd3) begin
            segs_cl = 5'd3;
        end else if (i_segments > 5'(MAX_SEGMENTS)) begin
            segs_cl = 5'(MAX_SEGMENTS);
        end else begin
            segs_cl = i_segments;
        end
    end

    // one table lookup and one multiplier, cosine then sine
    assign trig_phase = (r_state == ST_MULX) ? (r_p + QUARTER) : r_p;

    rcgb_trig #(.TRIG_TABLE_BITS(TB)) u_trig (
        .i_phase(trig_phase),
        .o_sine (trig_val)
    );

    assign prod = $signed({1'b0, r_w}) * trig_val;

    // restoring divide of 2^TB by the segment count, one bit a cycle
    assign div_try  = {r_drem, (r_dcnt == DW'(TB))};
    assign prem_sum = {1'b0, r_prem} + {1'b0, r_drem};

    assign match    = r_have && (r_btex == r_tex);
    assign bcount   = r_circ ? IB'(r_segs * 7'd3) : IB'(6);
    assign nb_ind   = match ? (r_bind + bcount) : bcount;
    assign nb_start = match ? r_bstart : (r_have ? (r_bstart + r_bind) : '0);
    assign tri_done = r_circ ? (r_cnt == r_segs - 5'd1) : (r_cnt == 5'd1);

    assign u_sum = 19'(19'sd65537 + 19'(r_c));
    assign v_sum = 19'(19'sd65537 + 19'(r_s));

    always_comb begin
        n_out = '0;
        unique case (r_state)
            ST_VERT: begin
                n_out.kind  = KIND_VERTEX;
                n_out.color = r_color;
                if (r_circ) begin
                    n_out.x = r_px;
                    n_out.y = r_py;
                    n_out.u = HALF_Q16;
                    n_out.v = HALF_Q16;
                end else begin
                    n_out.x = sat_add(r_px, r_cnt[0] ? $signed({3'b0, r_w}) : 18'sd0);
                    n_out.y = sat_add(r_py, r_cnt[1] ? $signed({3'b0, r_h}) : 18'sd0);
                    n_out.u = r_cnt[0] ? ONE_Q16 : '0;
                    n_out.v = r_cnt[1] ? ONE_Q16 : '0;
                end
            end
            ST_RIM: begin
                n_out.kind  = KIND_VERTEX;
                n_out.color = r_color;
                n_out.x     = sat_add(r_px, round_scale(r_prodx));
                n_out.y     = sat_add(r_py, round_scale(r_prody));
                n_out.u     = u_sum[17:1];
                n_out.v     = v_sum[17:1];
            end
            ST_TRI: begin
                n_out.kind = KIND_TRIANGLE;
                if (r_circ) begin
                    n_out.a = 20'(r_base);
                    n_out.b = 20'(r_base + IB'(r_cnt) + IB'(1));
                    n_out.c = (r_cnt == r_segs - 5'd1) ? 20'(r_base + IB'(1))
                                                       : 20'(r_base + IB'(r_cnt) + IB'(2));
                end else if (r_cnt[0]) begin
                    n_out.a = 20'(r_base + IB'(1));
                    n_out.b = 20'(r_base + IB'(3));
                    n_out.c = 20'(r_base + IB'(2));
                end else begin
                    n_out.a = 20'(r_base);
                    n_out.b = 20'(r_base + IB'(1));
                    n_out.c = 20'(r_base + IB'(2));
                end
            end
            ST_BATCH: begin
                n_out.kind = match ? KIND_EXTEND : KIND_OPEN;
                n_out.off  = 20'(nb_start);
                n_out.cnt  = 20'(nb_ind);
                n_out.last = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cnt = '0;
                    if (i_req_type == REQ_RECT) begin
                        n_state = ST_VERT;
                    end else if (i_req_type == REQ_CIRCLE) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (r_dcnt == '0) begin
                    n_state = ST_VERT;
                end
            end
            ST_VERT: begin
                if (load) begin
                    if (r_circ) begin
                        n_state = ST_MULX;
                    end else if (r_cnt == 5'd3) begin
                        n_state = ST_TRI;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            ST_MULX: n_state = ST_MULY;
            ST_MULY: n_state = ST_RIM;
            ST_RIM: begin
                if (load) begin
                    if (r_cnt == r_segs - 5'd1) begin
                        n_state = ST_TRI;
                        n_cnt   = '0;
                    end else begin
                        n_state = ST_MULX;
                        n_cnt   = r_cnt + 5'd1;
                    end
                end
            end
            ST_TRI: begin
                if (load) begin
                    if (tri_done) begin
                        n_state = ST_BATCH;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            ST_BATCH: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_vtotal <= '0;
            r_have   <= 1'b0;
            r_btex   <= '0;
            r_bstart <= '0;
            r_bind   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (in_acc && (i_req_type == REQ_CLEAR)) begin
                r_vtotal <= '0;
                r_have   <= 1'b0;
                r_btex   <= '0;
                r_bstart <= '0;
                r_bind   <= '0;
            end
            if (load && (r_state == ST_BATCH)) begin
                r_vtotal <= r_circ ? (r_base + IB'(r_segs) + IB'(1)) : (r_base + IB'(4));
                r_have   <= 1'b1;
                r_btex   <= r_tex;
                r_bstart <= nb_start;
                r_bind   <= nb_ind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_circ  <= (i_req_type == REQ_CIRCLE);
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_w     <= i_extent_w;
            r_h     <= i_extent_h;
            r_segs  <= segs_cl;
            r_color <= i_color;
            r_tex   <= i_texture_id;
            r_base  <= r_vtotal;
            r_dcnt  <= DW'(TB);
            r_drem  <= '0;
            r_q     <= '0;
            r_p     <= '0;
            r_prem  <= segs_cl >> 1;
        end
        if (r_state == ST_DIV) begin
            r_dcnt <= r_dcnt - DW'(1);
            if (div_try >= {1'b0, r_segs}) begin
                r_drem <= 5'(div_try - {1'b0, r_segs});
                r_q    <= {r_q[TB-2:0], 1'b1};
            end else begin
                r_drem <= div_try[4:0];
                r_q    <= {r_q[TB-2:0], 1'b0};
            end
        end
        if (r_state == ST_MULX) begin
            r_prodx <= prod;
            r_c     <= trig_val;
        end
        if (r_state == ST_MULY) begin
            r_prody <= prod;
            r_s     <= trig_val;
        end
        // next rim phase: add quotient, carry the remainder
        if (load && (r_state == ST_RIM)) begin
            if (prem_sum >= {1'b0, r_segs}) begin
                r_prem <= 5'(prem_sum - {1'b0, r_segs});
                r_p    <= r_p + r_q + TB'(1);
            end else begin
                r_prem <= prem_sum[4:0];
                r_p    <= r_p + r_q;
            end
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_kind         = r_out.kind;
    assign o_vert_x       = r_out.x;
    assign o_vert_y       = r_out.y;
    assign o_tex_u        = r_out.u;
    assign o_tex_v        = r_out.v;
    assign o_vert_color   = r_out.color;
    assign o_index_a      = r_out.a;
    assign o_index_b      = r_out.b;
    assign o_index_c      = r_out.c;
    assign o_batch_offset = r_out.off;
    assign o_batch_count  = r_out.cnt;
    assign o_last         = r_out.last;

    `RCGB_ASSERT_NEXT(a_batch_ends_req, load && (r_state == ST_BATCH), o_in_ready)
    `RCGB_ASSERT_NOW(a_rim_in_range, r_state == ST_RIM, r_cnt < r_segs)
    `RCGB_ASSERT_NOW(a_prem_below_segs, r_state != ST_IDLE, r_prem < r_segs)
    `RCGB_ASSERT_NEXT(a_rect_starts, in_acc && (i_req_type == REQ_RECT), r_state == ST_VERT)

endmodule

@@ test/rect_circle_geometry_batcher_checker.sv @@
`timescale 1ns / 100ps

module rect_circle_geometry_batcher_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [14:0]        i_extent_w,
    input  logic [14:0]        i_extent_h,
    input  logic [4:0]         i_segments,
    input  logic [31:0]        i_color,
    input  logic [15:0]        i_texture_id,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_vert_x,
    input  logic signed [15:0] i_vert_y,
    input  logic [16:0]        i_tex_u,
    input  logic [16:0]        i_tex_v,
    input  logic [31:0]        i_vert_color,
    input  logic [19:0]        i_index_a,
    input  logic [19:0]        i_index_b,
    input  logic [19:0]        i_index_c,
    input  logic [19:0]        i_batch_offset,
    input  logic [19:0]        i_batch_count,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);
    import rcgb_pkg::*;

    localparam int MAX_SEGS   = 31;
    localparam int TRIG_BITS  = 10;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [31:0]        color;
        logic [19:0]        a;
        logic [19:0]        b;
        logic [19:0]        c;
        logic [19:0]        offset;
        logic [19:0]        count;
        logic               last;
    } t_geom_beat;

    t_geom_beat expected_beats[$];

    logic [19:0] vert_total;
    logic        batch_live;
    logic [15:0] batch_tex;
    logic [19:0] batch_base;
    logic [19:0] batch_len;

    assign o_pending = expected_beats.size();

    function automatic longint quarter_wave_sine(longint unsigned r, longint unsigned q);
        longint unsigned x, x2, t3, t5, t7, t9, t11, s, q16;
        x   = (r * PI_HALF_Q30 + q / 2) / q;
        x2  = (x * x) >> 30;
        t3  = ((x * x2) >> 30) / 6;
        t5  = ((t3 * x2) >> 30) / 20;
        t7  = ((t5 * x2) >> 30) / 42;
        t9  = ((t7 * x2) >> 30) / 72;
        t11 = ((t9 * x2) >> 30) / 110;
        s   = x + t5 + t9 - t3 - t7 - t11;
        q16 = (s + 8192) >> 14;
        if (q16 > 65536) begin
            q16 = 65536;
        end
        return longint'(q16);
    endfunction

    function automatic longint sine_of_phase(int unsigned p);
        longint unsigned q;
        int unsigned quad, r;
        longint s;
        q    = 64'd1 << (TRIG_BITS - 2);
        p    = p & ((1 << TRIG_BITS) - 1);
        quad = p >> (TRIG_BITS - 2);
        r    = p & 32'(q - 1);
        s    = quad[0] ? quarter_wave_sine(q - r, q) : quarter_wave_sine(r, q);
        return quad[1] ? -s : s;
    endfunction

    function automatic longint radius_times(longint radius, longint t);
        longint prod, m;
        prod = radius * t;
        m    = ((prod < 0 ? -prod : prod) + 32768) >>> 16;
        return prod < 0 ? -m : m;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic void queue_beat(t_geom_beat e);
        expected_beats.insert(expected_beats.size(), e);
    endfunction

    function automatic void push_vertex(longint x, longint y, longint u, longint v,
                                        logic [31:0] col);
        t_geom_beat e;
        e = '0;
        e.kind = KIND_VERTEX;
        e.x = clamp16(x);
        e.y = clamp16(y);
        e.u = u[16:0];
        e.v = v[16:0];
        e.color = col;
        queue_beat(e);
    endfunction

    function automatic void push_triangle(logic [19:0] a, logic [19:0] b, logic [19:0] c);
        t_geom_beat e;
        e = '0;
        e.kind = KIND_TRIANGLE;
        e.a = a;
        e.b = b;
        e.c = c;
        queue_beat(e);
    endfunction

    function automatic void push_batch(logic [19:0] n, logic [15:0] tex);
        t_geom_beat e;
        e = '0;
        if (batch_live && batch_tex == tex) begin
            batch_len = batch_len + n;
            e.kind = KIND_EXTEND;
        end else begin
            batch_base = batch_live ? batch_base + batch_len : 20'd0;
            batch_len  = n;
            batch_tex  = tex;
            batch_live = 1'b1;
            e.kind = KIND_OPEN;
        end
        e.offset = batch_base;
        e.count = batch_len;
        e.last = 1'b1;
        queue_beat(e);
    endfunction

    function automatic void predict_request();
        longint px, py, w, h, c, s;
        int unsigned segs, p, nxt;
        logic [19:0] base;
        px = i_pos_x;
        py = i_pos_y;
        w = i_extent_w;
        h = i_extent_h;
        base = vert_total;
        if (i_req_type == REQ_CLEAR) begin
            vert_total = '0;
            batch_live = 1'b0;
            batch_tex = '0;
            batch_base = '0;
            batch_len = '0;
        end else if (i_req_type == REQ_RECT) begin
            push_vertex(px, py, 0, 0, i_color);
            push_vertex(px + w, py, 65536, 0, i_color);
            push_vertex(px, py + h, 0, 65536, i_color);
            push_vertex(px + w, py + h, 65536, 65536, i_color);
            push_triangle(base, base + 20'd1, base + 20'd2);
            push_triangle(base + 20'd1, base + 20'd3, base + 20'd2);
            vert_total = base + 20'd4;
            push_batch(20'd6, i_texture_id);
        end else if (i_req_type == REQ_CIRCLE) begin
            segs = i_segments;
            if (segs < 3) segs = 3;
            if (segs > MAX_SEGS) segs = MAX_SEGS;
            push_vertex(px, py, 32768, 32768, i_color);
            for (int unsigned i = 0; i < segs; i++) begin
                p = ((i << TRIG_BITS) + segs / 2) / segs;
                c = sine_of_phase(p + (1 << (TRIG_BITS - 2)));
                s = sine_of_phase(p);
                push_vertex(px + radius_times(w, c), py + radius_times(w, s),
                            (65537 + c) >>> 1, (65537 + s) >>> 1, i_color);
            end
            for (int unsigned i = 0; i < segs; i++) begin
                nxt = (i == segs - 1) ? 1 : i + 2;
                push_triangle(base, base + 20'(1 + i), base + 20'(nxt));
            end
            vert_total = base + 20'(1 + segs);
            push_batch(20'(segs * 3), i_texture_id);
        end
    endfunction

    always @(posedge i_clk) begin
        t_geom_beat got, want;
        if (!i_rst_n) begin
            vert_total = '0;
            batch_live = 1'b0;
            batch_tex = '0;
            batch_base = '0;
            batch_len = '0;
            o_fail_count <= 0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_kind, i_vert_x, i_vert_y, i_tex_u, i_tex_v, i_vert_color, i_index_a,
                       i_index_b, i_index_c, i_batch_offset, i_batch_count, i_last};
                if (expected_beats.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected beat %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) $display("mismatch exp %p got %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // blocking updates of predictor state; request after the output beat
            if (i_in_valid && i_in_ready) predict_request();
        end
    end

endmodule

@@ test/rect_circle_geometry_batcher_core_tb.sv @@
`timescale 1ns / 100ps

module rect_circle_geometry_batcher_core_tb;
    import rcgb_pkg::*;

    // request code the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = '0;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic [14:0]        extent_w = '0;
    logic [14:0]        extent_h = '0;
    logic [4:0]         segments = '0;
    logic [31:0]        color = '0;
    logic [15:0]        texture_id = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         kind;
    logic signed [15:0] vert_x, vert_y;
    logic [16:0]        tex_u, tex_v;
    logic [31:0]        vert_color;
    logic [19:0]        index_a, index_b, index_c, batch_offset, batch_count;
    logic               last;
    int                 fail_count;
    int                 pending;
    bit                 long_hold = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rect_circle_geometry_batcher_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_req_type(req_type), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_extent_w(extent_w), .i_extent_h(extent_h), .i_segments(segments),
        .i_color(color), .i_texture_id(texture_id),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_kind(kind), .o_vert_x(vert_x), .o_vert_y(vert_y),
        .o_tex_u(tex_u), .o_tex_v(tex_v), .o_vert_color(vert_color),
        .o_index_a(index_a), .o_index_b(index_b), .o_index_c(index_c),
        .o_batch_offset(batch_offset), .o_batch_count(batch_count), .o_last(last)
    );

    rect_circle_geometry_batcher_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_req_type(req_type), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_extent_w(extent_w), .i_extent_h(extent_h), .i_segments(segments),
        .i_color(color), .i_texture_id(texture_id),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_kind(kind), .i_vert_x(vert_x), .i_vert_y(vert_y),
        .i_tex_u(tex_u), .i_tex_v(tex_v), .i_vert_color(vert_color),
        .i_index_a(index_a), .i_index_b(index_b), .i_index_c(index_c),
        .i_batch_offset(batch_offset), .i_batch_count(batch_count), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern, with a long hold-off when asked
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            if ($urandom_range(0, 49) == 0) mode = int'($urandom_range(0, 3));
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    task automatic send_request(input logic [1:0] rt, input logic signed [15:0] x,
                                input logic signed [15:0] y, input logic [14:0] w,
                                input logic [14:0] h, input logic [4:0] sg,
                                input logic [31:0] col, input logic [15:0] tex);
        in_valid <= 1'b1;
        req_type <= rt;
        pos_x <= x;
        pos_y <= y;
        extent_w <= w;
        extent_h <= h;
        segments <= sg;
        color <= col;
        texture_id <= tex;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic send_random();
        logic [1:0] rt;
        logic [15:0] tex;
        int pick;
        pick = int'($urandom_range(0, 19));
        rt = (pick < 9) ? REQ_RECT : (pick < 18) ? REQ_CIRCLE :
             (pick == 18) ? REQ_CLEAR : REQ_UNUSED;
        // small set of textures so batches get extended often
        tex = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
        send_request(rt, 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                     ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6)),
                     $urandom, tex);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int burst;
        int gap;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, all request types, clamps and saturation
        send_request(REQ_RECT, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 5'd0,
                     32'hffffffff, 16'd0);
        send_request(REQ_RECT, 16'sh8000, 16'sh8000, 15'd0, 15'd0, 5'h1f, 32'd0, 16'd0);
        send_request(REQ_RECT, 16'sd0, 16'sd0, 15'h7fff, 15'd0, 5'd0, 32'h12345678, 16'hffff);
        send_request(REQ_CIRCLE, 16'sd0, 16'sd0, 15'h7fff, 15'd0, 5'd0, 32'haaaa5555,
                     16'hffff);
        send_request(REQ_CIRCLE, 16'sh7fff, 16'sh8000, 15'h7fff, 15'h7fff, 5'd1, 32'd1, 16'd5);
        send_request(REQ_CIRCLE, 16'sh8000, 16'sh7fff, 15'h7fff, 15'd0, 5'd2, 32'd2, 16'd5);
        send_request(REQ_CIRCLE, 16'sd100, -16'sd100, 15'd16, 15'd0, 5'd3, 32'd3, 16'd5);
        send_request(REQ_CIRCLE, 16'sd0, 16'sd0, 15'h4000, 15'd0, 5'd31, 32'd4, 16'd6);
        send_request(REQ_CIRCLE, 16'sd0, 16'sd0, 15'd1, 15'd0, 5'd30, 32'd5, 16'd6);
        send_request(REQ_UNUSED, 16'sd1, 16'sd2, 15'd3, 15'd4, 5'd5, 32'd6, 16'd7);
        send_request(REQ_CLEAR, 16'sd0, 16'sd0, 15'd0, 15'd0, 5'd0, 32'd0, 16'd0);
        send_request(REQ_RECT, -16'sd5, 16'sd7, 15'd20, 15'd30, 5'd0, 32'h55aa55aa, 16'd0);
        send_request(REQ_RECT, 16'sd1, 16'sd2, 15'd3, 15'd4, 5'd0, 32'h0, 16'd0);
        drain();
        // sender keeps offering while the receiver holds off
        long_hold = 1'b1;
        for (int i = 0; i < 40; i++) send_random();
        drain();
        for (int n = 0; n < 420; ) begin
            burst = int'($urandom_range(1, 12));
            while (burst > 0 && n < 420) begin
                burst--;
                n++;
                send_random();
            end
            gap = int'($urandom_range(0, 6));
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            if ($urandom_range(0, 40) == 0) drain();
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
